FILE: design/pswc_pkg.sv
// Package for the PWM shadow write coalescer.
// Holds operation and step codes, controller state and command types,
// and the per-channel register address table. No dependencies.
`default_nettype none

package pswc_pkg;

    // Operation codes of a request
    localparam logic [2:0] OP_SET   = 3'd0;
    localparam logic [2:0] OP_UP    = 3'd1;
    localparam logic [2:0] OP_DOWN  = 3'd2;
    localparam logic [2:0] OP_FLUSH = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Pending step codes
    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_DOWN = 2'd1;
    localparam logic [1:0] STEP_UP   = 2'd2;

    // Result kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // Frame lengths in bytes
    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;       // request taken this cycle
        logic rd_single;    // read the addressed channel
        logic scan_start;   // start a flush scan at channel zero
        logic eval_single;  // apply a set or capture a read
        logic scan_step;    // one flush scan step
        logic done;         // emit the done result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_end;     // every channel has been read
    } t_stat;

    // Low register address of a channel, repeating every sixteen channels
    function automatic logic [7:0] addr_low(input logic [3:0] ch);
        logic [7:0] a;
        case (ch)
            4'd0:    a = 8'h40;
            4'd1:    a = 8'h44;
            4'd2:    a = 8'h3C;
            4'd3:    a = 8'h38;
            4'd4:    a = 8'h10;
            4'd5:    a = 8'h14;
            4'd6:    a = 8'h0C;
            4'd7:    a = 8'h08;
            4'd8:    a = 8'h20;
            4'd9:    a = 8'h24;
            4'd10:   a = 8'h1C;
            4'd11:   a = 8'h18;
            4'd12:   a = 8'h30;
            4'd13:   a = 8'h34;
            4'd14:   a = 8'h2C;
            4'd15:   a = 8'h28;
            default: a = 8'h40;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: design/pswc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pswc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                     i_wr_data,
    input  wire logic                                 i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: design/pswc_ctrl.sv
// Controller state machine of the PWM shadow write coalescer.
// Depends on pswc_pkg for states, opcodes and the command/status structs.
`default_nettype none

module pswc_ctrl
    import pswc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [2:0] i_operation,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd,
    output logic            o_busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_operation)
                        OP_SET, OP_READ: n_state = S_EVAL;
                        OP_FLUSH:        n_state = S_SCAN;
                        default:         n_state = S_DONE;
                    endcase
                end
            end
            S_EVAL: n_state = S_DONE;
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
                if (i_start) begin
                    o_cmd.rd_single  = (i_operation == OP_SET) || (i_operation == OP_READ);
                    o_cmd.scan_start = (i_operation == OP_FLUSH);
                end
            end
            S_EVAL:  o_cmd.eval_single = 1'b1;
            S_SCAN:  o_cmd.scan_step   = 1'b1;
            S_DONE:  o_cmd.done        = 1'b1;
            default: o_busy            = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/pswc_dpath.sv
// Datapath of the PWM shadow write coalescer: shadow value RAM, valid and
// pending-step flags, flush scan counter, frame builder and result registers.
// Depends on pswc_pkg and pswc_ram.
`default_nettype none

module pswc_dpath
    import pswc_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int PWM_MAX      = 4095
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [2:0]  i_operation,
    input  wire logic [3:0]  i_led_index,
    input  wire logic [15:0] i_value,
    output t_stat            o_stat,
    output logic             o_valid,
    output logic             o_kind,
    output logic [1:0]       o_frame_length,
    output logic [7:0]       o_byte_first,
    output logic [7:0]       o_byte_second,
    output logic [7:0]       o_byte_third,
    output logic [11:0]      o_read_value,
    output logic             o_last
);

    localparam int CW = $clog2(PWM_MAX + 1);
    localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SW = $clog2(NUM_CHANNELS + 1);

    // Latched request
    logic [2:0]    r_op;
    logic [IW-1:0] r_idx;
    logic [15:0]   r_val;
    logic          r_ok;

    // Channel flags, scan counter, read capture
    logic [NUM_CHANNELS-1:0] r_vld;
    logic [1:0]              r_pend [NUM_CHANNELS];
    logic [SW-1:0]           r_scan;
    logic                    r_rd_vld;
    logic [CW-1:0]           r_hold;

    // Result registers
    logic        r_o_valid;
    logic        r_o_kind;
    logic [1:0]  r_o_len;
    logic [7:0]  r_o_b1;
    logic [7:0]  r_o_b2;
    logic [7:0]  r_o_b3;
    logic [11:0] r_o_rv;
    logic        r_o_last;

    logic          l_in_ok;
    logic [IW-1:0] l_in_idx;
    logic          l_rd_en;
    logic [IW-1:0] l_rd_addr;
    logic [CW-1:0] l_rd_data;
    logic [IW-1:0] l_eidx;
    logic [CW-1:0] l_ov;
    logic [CW-1:0] l_nv;
    logic          l_wr;
    logic [15:0]   l_ov16;
    logic [15:0]   l_nv16;
    logic [7:0]    l_addr;
    logic          l_lo_diff;
    logic          l_hi_diff;

    assign l_in_ok  = 32'(i_led_index) < NUM_CHANNELS;
    assign l_in_idx = IW'(i_led_index);

    assign o_stat.scan_end = (32'(r_scan) == NUM_CHANNELS);

    // RAM read address: addressed channel, first channel, or next scan channel
    always_comb begin
        l_rd_en   = i_cmd.rd_single || i_cmd.scan_start
                    || (i_cmd.scan_step && !o_stat.scan_end);
        l_rd_addr = r_scan[IW-1:0];
        if (i_cmd.rd_single) begin
            l_rd_addr = l_in_idx;
        end else if (i_cmd.scan_start) begin
            l_rd_addr = '0;
        end
    end

    // Evaluate the channel read last cycle: new value and write enable
    always_comb begin
        l_eidx = i_cmd.scan_step ? IW'(r_scan - SW'(1)) : r_idx;
        l_ov   = r_rd_vld ? l_rd_data : '0;
        l_nv   = l_ov;
        l_wr   = 1'b0;
        if (i_cmd.eval_single && (r_op == OP_SET) && r_ok && (32'(r_val) <= PWM_MAX)) begin
            l_wr = 1'b1;
            l_nv = CW'(r_val);
        end
        if (i_cmd.scan_step) begin
            case (r_pend[l_eidx])
                STEP_UP: begin
                    if (32'(l_ov) < PWM_MAX) begin
                        l_wr = 1'b1;
                        l_nv = l_ov + CW'(1);
                    end
                end
                STEP_DOWN: begin
                    if (l_ov != '0) begin
                        l_wr = 1'b1;
                        l_nv = l_ov - CW'(1);
                    end
                end
                default: l_wr = l_wr;
            endcase
        end
    end

    // Byte comparison for the minimal frame
    assign l_ov16    = 16'(l_ov);
    assign l_nv16    = 16'(l_nv);
    assign l_addr    = addr_low(4'(l_eidx));
    assign l_lo_diff = l_ov16[7:0] != l_nv16[7:0];
    assign l_hi_diff = l_ov16[15:8] != l_nv16[15:8];

    pswc_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_CHANNELS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (l_wr),
        .i_wr_addr (l_eidx),
        .i_wr_data (l_nv),
        .i_rd_en   (l_rd_en),
        .i_rd_addr (l_rd_addr),
        .o_rd_data (l_rd_data)
    );

    // Request capture, read capture and scan counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_operation;
            r_idx <= l_in_idx;
            r_val <= i_value;
            r_ok  <= l_in_ok;
        end
        if (l_rd_en) begin
            r_rd_vld <= r_vld[l_rd_addr];
        end
        if (i_cmd.eval_single) begin
            r_hold <= r_ok ? l_ov : '0;
        end
        if (i_cmd.scan_start) begin
            r_scan <= SW'(1);
        end else if (i_cmd.scan_step && !o_stat.scan_end) begin
            r_scan <= r_scan + SW'(1);
        end
    end

    // Valid and pending flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_pend[i] <= STEP_NONE;
            end
        end else begin
            if (l_wr) begin
                r_vld[l_eidx] <= 1'b1;
            end
            if (i_cmd.accept && l_in_ok && (i_operation == OP_UP)) begin
                r_pend[l_in_idx] <= STEP_UP;
            end
            if (i_cmd.accept && l_in_ok && (i_operation == OP_DOWN)) begin
                r_pend[l_in_idx] <= STEP_DOWN;
            end
            if (i_cmd.scan_step) begin
                r_pend[l_eidx] <= STEP_NONE;
            end
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.done || (l_wr && (l_lo_diff || l_hi_diff));
        end
    end

    // Result payload: done marker or write frame
    always_ff @(posedge i_clk) begin
        r_o_kind <= KIND_FRAME;
        r_o_len  <= LEN_TWO;
        r_o_b1   <= l_addr;
        r_o_b2   <= l_nv16[7:0];
        r_o_b3   <= 8'd0;
        r_o_rv   <= 12'd0;
        r_o_last <= 1'b0;
        if (i_cmd.done) begin
            r_o_kind <= KIND_DONE;
            r_o_len  <= LEN_NONE;
            r_o_b1   <= 8'd0;
            r_o_b2   <= 8'd0;
            r_o_rv   <= (r_op == OP_READ) ? 12'(r_hold) : 12'd0;
            r_o_last <= 1'b1;
        end else if (l_lo_diff && l_hi_diff) begin
            r_o_len <= LEN_THREE;
            r_o_b3  <= l_nv16[15:8];
        end else if (!l_lo_diff) begin
            // high part only
            r_o_b1 <= l_addr + 8'd1;
            r_o_b2 <= l_nv16[15:8];
        end
    end

    assign o_valid        = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_frame_length = r_o_len;
    assign o_byte_first   = r_o_b1;
    assign o_byte_second  = r_o_b2;
    assign o_byte_third   = r_o_b3;
    assign o_read_value   = r_o_rv;
    assign o_last         = r_o_last;

endmodule

`default_nettype wire

FILE: design/pwm_shadow_write_coalescer.sv
// PWM shadow write coalescer, top level.
// Sequence: a set or read goes from the accepting idle state through evaluate to done; marks and
// unknown operations go straight to done; a flush scans one channel per cycle through the RAM read port.
// One request at a time; busy stays high through the done cycle, so a new request is taken only
// once the block is back in idle. Results strobe one cycle each and cannot be stalled.
// Synchronous active-low reset clears all valid flags, so values read as zero, and pending steps.
`default_nettype none

module pwm_shadow_write_coalescer
    import pswc_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int PWM_MAX      = 4095
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_operation,
    input  wire logic [3:0]  i_led_index,
    input  wire logic [15:0] i_value,
    output logic             o_valid,
    output logic             o_kind,
    output logic [1:0]       o_frame_length,
    output logic [7:0]       o_byte_first,
    output logic [7:0]       o_byte_second,
    output logic [7:0]       o_byte_third,
    output logic [11:0]      o_read_value,
    output logic             o_last
);

    t_cmd  l_cmd;
    t_stat l_stat;

    pswc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_stat      (l_stat),
        .o_cmd       (l_cmd),
        .o_busy      (busy)
    );

    pswc_dpath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .PWM_MAX      (PWM_MAX)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (l_cmd),
        .i_operation    (i_operation),
        .i_led_index    (i_led_index),
        .i_value        (i_value),
        .o_stat         (l_stat),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_frame_length (o_frame_length),
        .o_byte_first   (o_byte_first),
        .o_byte_second  (o_byte_second),
        .o_byte_third   (o_byte_third),
        .o_read_value   (o_read_value),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the PWM shadow write coalescer.
// Drives set, step, flush and read requests and predicts every write frame and done result.
// Depends on pswc_pkg and pwm_shadow_write_coalescer.
`timescale 1ns / 1ps

module tb_top;
    import pswc_pkg::*;

    localparam int          NUM_CH      = 16;
    localparam logic [11:0] VALUE_MAX   = 12'hFFF;
    localparam logic [2:0]  OP_RSVD_LO  = 3'd5;
    localparam logic [2:0]  OP_RSVD_HI  = 3'd7;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          ITEMS_MIXED = 190;
    localparam int          ITEMS_TOTAL = 230;
    localparam int          SETTLE_CYC  = 40;

    // One result as seen on the output strobe
    typedef struct packed {
        logic       kind;
        logic [1:0] frame_len;
        logic [7:0] reg_addr;
        logic [7:0] data_lo;
        logic [7:0] data_hi;
        logic [11:0] rd_value;
        logic       last;
    } t_reg_write;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_operation;
    logic [3:0]  i_led_index;
    logic [15:0] i_value;
    logic        o_valid;
    logic        o_kind;
    logic [1:0]  o_frame_length;
    logic [7:0]  o_byte_first;
    logic [7:0]  o_byte_second;
    logic [7:0]  o_byte_third;
    logic [11:0] o_read_value;
    logic        o_last;

    // Predictor state: shadow copy of the channel table and the step marks
    logic [11:0] shadow_val [NUM_CH];
    logic [1:0]  step_mark [NUM_CH];
    logic [7:0]  reg_addr_tbl [16] = '{
        8'h40, 8'h44, 8'h3C, 8'h38, 8'h10, 8'h14, 8'h0C, 8'h08,
        8'h20, 8'h24, 8'h1C, 8'h18, 8'h30, 8'h34, 8'h2C, 8'h28
    };

    t_reg_write expected_writes[$];
    int         fail_count;
    int         items_sent;
    int         cycle_count;
    bit         idle_en;

    pwm_shadow_write_coalescer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_led_index    (i_led_index),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_frame_length (o_frame_length),
        .o_byte_first   (o_byte_first),
        .o_byte_second  (o_byte_second),
        .o_byte_third   (o_byte_third),
        .o_read_value   (o_read_value),
        .o_last         (o_last)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Store a new channel value and queue the shortest write frame for the change
    function automatic void write_channel(input logic [3:0] ch, input logic [11:0] nv);
        logic [11:0] ov;
        logic [7:0]  addr;
        t_reg_write  w;
        ov   = shadow_val[ch];
        addr = reg_addr_tbl[ch];
        shadow_val[ch] = nv;
        w = '{KIND_FRAME, LEN_TWO, addr, nv[7:0], 8'h00, 12'h000, 1'b0};
        if (ov[7:0] != nv[7:0]) begin
            if (ov[11:8] != nv[11:8]) begin
                w.frame_len = LEN_THREE;
                w.data_hi   = {4'h0, nv[11:8]};
            end
            expected_writes.push_back(w);
        end else if (ov[11:8] != nv[11:8]) begin
            w.reg_addr = addr + 8'd1;
            w.data_lo  = {4'h0, nv[11:8]};
            expected_writes.push_back(w);
        end
    endfunction

    // Work out every result that one accepted request causes
    function automatic void coalesce_request(input logic [2:0] op, input logic [3:0] idx,
                                             input logic [15:0] val);
        logic [11:0] rd;
        logic [11:0] v;
        rd = 12'h000;
        case (op)
            OP_SET: begin
                if (val <= {4'h0, VALUE_MAX})
                    write_channel(idx, val[11:0]);
            end
            OP_UP:   step_mark[idx] = STEP_UP;
            OP_DOWN: step_mark[idx] = STEP_DOWN;
            OP_FLUSH: begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    v = shadow_val[ch];
                    if (step_mark[ch] == STEP_UP && v != VALUE_MAX)
                        write_channel(4'(ch), v + 12'd1);
                    else if (step_mark[ch] == STEP_DOWN && v != 12'h000)
                        write_channel(4'(ch), v - 12'd1);
                    step_mark[ch] = STEP_NONE;
                end
            end
            OP_READ: rd = shadow_val[idx];
            default: ;
        endcase
        expected_writes.push_back('{KIND_DONE, LEN_NONE, 8'h00, 8'h00, 8'h00, rd, 1'b1});
    endfunction

    // Send one request, with an optional idle burst first
    task automatic send_request(input logic [2:0] op, input logic [3:0] idx,
                                input logic [15:0] val);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 9);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start       <= 1'b1;
        i_operation <= op;
        i_led_index <= idx;
        i_value     <= val;
        do @(posedge i_clk); while (busy);
        coalesce_request(op, idx, val);
        items_sent++;
    endtask

    // Lower start and wait for every outstanding result
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_writes.size() != 0) @(posedge i_clk);
    endtask

    // Values biased towards the frame and saturation boundaries
    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h0000;
            1:       v = 16'h0FFF;
            2:       v = 16'h00FF;
            3:       v = 16'h0100;
            4:       v = 16'(16'h1000 + $urandom_range(0, 16'hEFFF));
            5:       v = 16'($urandom_range(0, 16'hFFFF));
            6:       v = 16'(16'h0100 * $urandom_range(0, 15) + $urandom_range(0, 1));
            default: v = 16'($urandom_range(0, 12'hFFF));
        endcase
        return v;
    endfunction

    // Frame shapes: three-byte, low-only, high-only, unchanged, plus reads
    task automatic test_set_frames();
        send_request(OP_SET, 4'd0, 16'd4095);
        send_request(OP_SET, 4'd0, 16'd4096);
        send_request(OP_SET, 4'd0, 16'hFFFF);
        send_request(OP_SET, 4'd1, 16'h00FF);
        send_request(OP_SET, 4'd1, 16'h01FF);
        send_request(OP_SET, 4'd1, 16'h01FF);
        send_request(OP_READ, 4'd0, 16'h0000);
        send_request(OP_READ, 4'd15, 16'hFFFF);
        send_request(OP_SET, 4'd15, 16'h0100);
    endtask

    // Saturating steps, a replaced mark, carries across the byte boundary
    task automatic test_step_flush();
        send_request(OP_UP, 4'd0, 16'h0000);
        send_request(OP_DOWN, 4'd2, 16'h0000);
        send_request(OP_UP, 4'd1, 16'h0000);
        send_request(OP_DOWN, 4'd1, 16'h0000);
        send_request(OP_SET, 4'd3, 16'h0100);
        send_request(OP_DOWN, 4'd3, 16'h0000);
        send_request(OP_UP, 4'd4, 16'h0000);
        send_request(OP_SET, 4'd5, 16'h00FF);
        send_request(OP_UP, 4'd5, 16'h0000);
        send_request(OP_FLUSH, 4'd0, 16'h0000);
        send_request(OP_FLUSH, 4'd9, 16'h0000);
        send_request(OP_READ, 4'd3, 16'h0000);
    endtask

    // Unknown operation codes give a done only
    task automatic test_unknown_ops();
        for (int op = OP_RSVD_LO; op <= OP_RSVD_HI; op++)
            send_request(3'(op), 4'($urandom_range(0, 15)), 16'($urandom_range(0, 16'hFFFF)));
        send_request(OP_READ, 4'd1, 16'h0000);
    endtask

    // One random request of any kind
    task automatic random_request(input bit hot);
        logic [3:0] idx;
        int         sel;
        idx = hot ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        sel = $urandom_range(0, 99);
        if (sel < 28)
            send_request(OP_SET, idx, pick_value());
        else if (sel < 44)
            send_request(OP_UP, idx, 16'($urandom_range(0, 16'hFFFF)));
        else if (sel < 60)
            send_request(OP_DOWN, idx, 16'($urandom_range(0, 16'hFFFF)));
        else if (sel < 72)
            send_request(OP_FLUSH, idx, 16'($urandom_range(0, 16'hFFFF)));
        else if (sel < 94)
            send_request(OP_READ, idx, 16'($urandom_range(0, 16'hFFFF)));
        else
            send_request(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), idx,
                         16'($urandom_range(0, 16'hFFFF)));
    endtask

    // Well-formed sequences: mark a few channels, some of them set first, then flush
    task automatic step_sequence();
        int n;
        logic [3:0] idx;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            idx = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 1))
                send_request(OP_SET, idx, pick_value());
            send_request($urandom_range(0, 1) ? OP_UP : OP_DOWN, idx, 16'h0000);
        end
        send_request(OP_FLUSH, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 16'hFFFF)));
    endtask

    // Every channel marked, so one flush gives a frame per channel that is not saturated
    task automatic full_flush();
        for (int ch = 0; ch < NUM_CH; ch++)
            send_request($urandom_range(0, 1) ? OP_UP : OP_DOWN, 4'(ch), 16'h0000);
        send_request(OP_FLUSH, 4'd0, 16'h0000);
    endtask

    task automatic test_random_mix();
        int sel;
        idle_en = 1'b1;
        while (items_sent < ITEMS_MIXED) begin
            sel = $urandom_range(0, 19);
            if (sel < 10)
                random_request(sel < 4);
            else if (sel < 18)
                step_sequence();
            else
                full_flush();
        end
    endtask

    // Sender holds off until the block has nothing outstanding
    task automatic test_drain_pause();
        drain_results();
        repeat ($urandom_range(1, 5)) @(posedge i_clk);
    endtask

    // Closing stretch with start held high back to back
    task automatic test_back_to_back();
        idle_en = 1'b0;
        while (items_sent < ITEMS_TOTAL) begin
            if ($urandom_range(0, 2) == 0)
                step_sequence();
            else
                random_request(1'($urandom_range(0, 1)));
        end
    endtask

    // Check each strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_reg_write want;
        t_reg_write got;
        if (i_rst_n && o_valid) begin
            got = '{o_kind, o_frame_length, o_byte_first, o_byte_second, o_byte_third,
                    o_read_value, o_last};
            if (expected_writes.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected result kind=%0d len=%0d %h %h %h rv=%h last=%0d",
                             got.kind, got.frame_len, got.reg_addr, got.data_lo,
                             got.data_hi, got.rd_value, got.last);
                fail_count++;
            end else begin
                want = expected_writes.pop_front();
                if (got.kind != want.kind || got.frame_len != want.frame_len
                        || got.reg_addr != want.reg_addr || got.data_lo != want.data_lo
                        || got.data_hi != want.data_hi || got.rd_value != want.rd_value
                        || got.last != want.last) begin
                    if (fail_count < 10)
                        $display("mismatch: exp kind=%0d len=%0d %h %h %h rv=%h last=%0d, %s",
                                 want.kind, want.frame_len, want.reg_addr, want.data_lo,
                                 want.data_hi, want.rd_value, want.last,
                                 $sformatf("got kind=%0d len=%0d %h %h %h rv=%h last=%0d",
                                           got.kind, got.frame_len, got.reg_addr,
                                           got.data_lo, got.data_hi, got.rd_value,
                                           got.last));
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_operation = OP_SET;
        i_led_index = 4'd0;
        i_value     = 16'h0000;
        idle_en     = 1'b1;
        fail_count  = 0;
        items_sent  = 0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            shadow_val[ch] = 12'h000;
            step_mark[ch]  = STEP_NONE;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_set_frames();
        test_step_flush();
        test_unknown_ops();
        test_random_mix();
        test_drain_pause();
        test_back_to_back();

        drain_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (fail_count == 0 && expected_writes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
